/* hw/rtl/ipr_pkg.sv */
// shared types and constants for the inverse perspective remap block
package ipr_pkg;

    localparam int COEF_W = 32;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int PIX_W  = 8;
    localparam int CFG_IDX_W = 3;
    // products are 32x(8 or 7) bits, sums of three stay within 42 bits
    localparam int ACC_W  = 42;
    localparam int QUOT_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_XI = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XJ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YJ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YC = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WI = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WJ = 3'd7;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             in_bounds;
    } rsp_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] xi;
        logic signed [COEF_W-1:0] xj;
        logic signed [COEF_W-1:0] xc;
        logic signed [COEF_W-1:0] yi;
        logic signed [COEF_W-1:0] yj;
        logic signed [COEF_W-1:0] yc;
        logic signed [COEF_W-1:0] wi;
        logic signed [COEF_W-1:0] wj;
    } coef_t;

    // item handed from the front to the back through the queue
    typedef struct packed {
        logic                    is_query;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic [PIX_W-1:0]        pixel;
    } job_t;

endpackage

/* hw/rtl/ipr_if.sv */
// valid/ready channel interfaces for requests and responses
interface ipr_req_if;
    import ipr_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipr_rsp_if;
    import ipr_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ipr_ram.sv */
// generic single-write, single-read ram with registered read
module ipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hw/rtl/ipr_fifo.sv */
// short job queue between front and back
module ipr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ipr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output ipr_pkg::job_t pop_data,
    output logic          empty
);
    import ipr_pkg::*;
    localparam int AW = $clog2(DEPTH);

    job_t          q_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= push_data;
        end
    end
endmodule

/* hw/rtl/ipr_divider.sv */
// pipelined restoring divider: magnitude quotient, one bit per stage
module ipr_divider #(
    parameter int NW = 42,
    parameter int QW = 12,
    parameter int TW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          stall,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic          out_ovf,
    output logic [QW-1:0] quot,
    output logic [TW-1:0] tag_out
);
    // overflow: quotient >= 2^QW, checked up front as num >= den << QW
    logic [NW-1:0]      r_reg  [QW+1];
    logic [NW-1:0]      d_reg  [QW+1];
    logic [QW-1:0]      q_reg  [QW+1];
    logic               v_reg  [QW+1];
    logic               o_reg  [QW+1];
    logic [TW-1:0]      t_reg  [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QW; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (!stall)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= QW; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            r_reg[0] <= num;
            d_reg[0] <= den;
            q_reg[0] <= '0;
            t_reg[0] <= tag_in;
            o_reg[0] <= ({{QW{1'b0}}, num} >= ({den, {QW{1'b0}}}));
            for (int s = 1; s <= QW; s++)
            begin
                logic [NW+QW-1:0] sh;
                sh = {{QW{1'b0}}, d_reg[s-1]} << (QW - s);
                if ({{QW{1'b0}}, r_reg[s-1]} >= sh)
                begin
                    r_reg[s] <= NW'({{QW{1'b0}}, r_reg[s-1]} - sh);
                    q_reg[s] <= q_reg[s-1] | (QW'(1) << (QW - s));
                end
                else
                begin
                    r_reg[s] <= r_reg[s-1];
                    q_reg[s] <= q_reg[s-1];
                end
                d_reg[s] <= d_reg[s-1];
                o_reg[s] <= o_reg[s-1];
                t_reg[s] <= t_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_ovf   = o_reg[QW];
    assign quot      = q_reg[QW];
    assign tag_out   = t_reg[QW];
endmodule

/* hw/rtl/ipr_front.sv */
// front end: accepts items, classifies loads and queries, pushes jobs
module ipr_front (
    ipr_req_if.sink       req,
    input  logic          q_full,
    output logic          push,
    output ipr_pkg::job_t push_data
);
    import ipr_pkg::*;
    assign req.ready          = !q_full;
    assign push               = req.valid && !q_full;
    assign push_data.is_query = (req.data.req_type == REQ_QUERY);
    assign push_data.col      = req.data.col;
    assign push_data.row      = req.data.row;
    assign push_data.pixel    = req.data.pixel_in;
endmodule

/* hw/rtl/ipr_back.sv */
// back end: coordinate transform, divide, bounds check, frame store access
module ipr_back #(
    parameter int SRC_WIDTH  = 256,
    parameter int SRC_HEIGHT = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ipr_pkg::coef_t coef,
    input  logic           q_empty,
    input  ipr_pkg::job_t  job,
    output logic           pop,
    ipr_rsp_if.source      rsp
);
    import ipr_pkg::*;
    localparam int AW     = $clog2(SRC_WIDTH * SRC_HEIGHT);
    localparam int DLAT   = QUOT_W + 1;
    // stages from the queue head to the lookup stage
    localparam int LD_LAT = DLAT + 3;
    localparam logic signed [ACC_W-1:0] ONE = ACC_W'(64'sd16777216);

    // the whole pipe advances together; it stalls while a result waits
    logic stall;
    logic s0_v_reg, s1_v_reg, s2_v_reg, rd_v_reg, out_v_reg;
    job_t s0_reg;
    logic signed [ACC_W-1:0] pxi_reg, pxj_reg, pyi_reg, pyj_reg, pwi_reg, pwj_reg;
    logic signed [ACC_W-1:0] x_reg, y_reg, w_reg;
    logic [ACC_W-1:0] ax, ay, aw;
    logic sgn_x, sgn_y;
    logic                 dx_v, dx_o, dy_o, dy_v;
    logic [QUOT_W-1:0]    qx, qy;
    logic [1:0]           tx, ty;
    logic [PIX_W-1:0]     rdata;
    logic                 ok, rd_ok_reg;
    logic [AW-1:0]        raddr;
    logic                 out_ib_reg;
    logic                 we;
    logic                 ld_in;
    logic [AW-1:0]        ld_addr;
    logic                 ld_v_reg    [LD_LAT];
    logic [AW-1:0]        ld_addr_reg [LD_LAT];
    logic [PIX_W-1:0]     ld_pix_reg  [LD_LAT];

    assign stall = out_v_reg && !rsp.ready;
    assign pop   = !q_empty && !stall;

    // loads ride the pipe and write at the lookup stage, so they keep order with queries
    assign ld_in   = pop && !job.is_query &&
                     ({3'b0, job.col} < 11'(SRC_WIDTH)) && ({4'b0, job.row} < 11'(SRC_HEIGHT));
    assign ld_addr = AW'(({12'b0, job.row} * 20'(SRC_WIDTH)) + {12'b0, job.col});
    assign we      = ld_v_reg[LD_LAT-1] && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LD_LAT; k++)
            begin
                ld_v_reg[k] <= 1'b0;
            end
        end
        else if (!stall)
        begin
            ld_v_reg[0] <= ld_in;
            for (int k = 1; k < LD_LAT; k++)
            begin
                ld_v_reg[k] <= ld_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            ld_addr_reg[0] <= ld_addr;
            ld_pix_reg[0]  <= job.pixel;
            for (int k = 1; k < LD_LAT; k++)
            begin
                ld_addr_reg[k] <= ld_addr_reg[k-1];
                ld_pix_reg[k]  <= ld_pix_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            rd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s0_v_reg  <= pop && job.is_query;
            s1_v_reg  <= s0_v_reg;
            rd_v_reg  <= dx_v && dy_v;
            out_v_reg <= rd_v_reg;
        end
    end

    // stage 0: latch job; stage 1: products; stage 2: sums
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s0_reg  <= job;
            pxi_reg <= ACC_W'(coef.xi * $signed({1'b0, s0_reg.col}));
            pxj_reg <= ACC_W'(coef.xj * $signed({1'b0, s0_reg.row}));
            pyi_reg <= ACC_W'(coef.yi * $signed({1'b0, s0_reg.col}));
            pyj_reg <= ACC_W'(coef.yj * $signed({1'b0, s0_reg.row}));
            pwi_reg <= ACC_W'(coef.wi * $signed({1'b0, s0_reg.col}));
            pwj_reg <= ACC_W'(coef.wj * $signed({1'b0, s0_reg.row}));
            x_reg   <= pxi_reg + pxj_reg + ACC_W'(coef.xc);
            y_reg   <= pyi_reg + pyj_reg + ACC_W'(coef.yc);
            w_reg   <= pwi_reg + pwj_reg + ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    assign ax    = x_reg[ACC_W-1] ? ACC_W'(-x_reg) : x_reg;
    assign ay    = y_reg[ACC_W-1] ? ACC_W'(-y_reg) : y_reg;
    assign aw    = w_reg[ACC_W-1] ? ACC_W'(-w_reg) : w_reg;
    assign sgn_x = x_reg[ACC_W-1] ^ w_reg[ACC_W-1];
    assign sgn_y = y_reg[ACC_W-1] ^ w_reg[ACC_W-1];

    // tag carries the result signs; the zero-divisor flag rides in o via aw==0
    ipr_divider #(.NW(ACC_W), .QW(QUOT_W), .TW(2)) u_div_x (
        .clk, .rst_n, .stall,
        .in_valid (s2_v_reg), .num (ax), .den (aw), .tag_in ({sgn_x, sgn_y}),
        .out_valid (dx_v), .out_ovf (dx_o), .quot (qx), .tag_out (tx)
    );
    ipr_divider #(.NW(ACC_W), .QW(QUOT_W), .TW(2)) u_div_y (
        .clk, .rst_n, .stall,
        .in_valid (s2_v_reg), .num (ay), .den (aw), .tag_in ({sgn_x, sgn_y}),
        .out_valid (dy_v), .out_ovf (dy_o), .quot (qy), .tag_out (ty)
    );

    // zero divisor makes the overflow test num >= 0 true, so it is out of bounds
    assign ok = !dx_o && !dy_o &&
                !(tx[1] && qx != '0) && !(ty[0] && qy != '0) &&
                (qx < QUOT_W'(SRC_WIDTH)) && (qy < QUOT_W'(SRC_HEIGHT));
    assign raddr = AW'(({10'b0, qy} * 22'(SRC_WIDTH)) + {10'b0, qx});

    ipr_ram #(.WIDTH(PIX_W), .DEPTH(SRC_WIDTH * SRC_HEIGHT)) u_frame (
        .clk, .we, .waddr (ld_addr_reg[LD_LAT-1]), .wdata (ld_pix_reg[LD_LAT-1]),
        .re (!stall), .raddr, .rdata
    );

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            rd_ok_reg  <= ok;
            out_ib_reg <= rd_ok_reg;
        end
    end

    logic [PIX_W-1:0] pix_reg;
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            pix_reg <= rd_ok_reg ? rdata : '0;
        end
    end

    assign rsp.valid          = out_v_reg;
    assign rsp.data.pixel_out = pix_reg;
    assign rsp.data.in_bounds = out_ib_reg;
endmodule

/* hw/rtl/inverse_perspective_pixel_remap_core.sv */
// top level of the inverse perspective pixel remap block
// a query passes through the queue, the transform stages, the divider pair and the frame store read
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined divider pair
// a stalled output freezes the back pipe; the 4-entry queue absorbs the front
// reset clears control state and loads coefficient reset values, not the frame store
module inverse_perspective_pixel_remap_core #(
    parameter int SRC_WIDTH  = 256,
    parameter int SRC_HEIGHT = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ipr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipr_pkg::COEF_W-1:0]    cfg_data,
    ipr_req_if.sink                       req,
    ipr_rsp_if.source                     rsp
);
    import ipr_pkg::*;

    // coefficient registers
    coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.xi <= 32'sd9181583;
            coef_reg.xj <= -32'sd12317865;
            coef_reg.xc <= 32'sd840477033;
            coef_reg.yi <= -32'sd439547;
            coef_reg.yj <= -32'sd3736555;
            coef_reg.yc <= 32'sd622135223;
            coef_reg.wi <= -32'sd9770;
            coef_reg.wj <= -32'sd142071;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XI:  coef_reg.xi <= cfg_data;
                REG_XJ:  coef_reg.xj <= cfg_data;
                REG_XC:  coef_reg.xc <= cfg_data;
                REG_YI:  coef_reg.yi <= cfg_data;
                REG_YJ:  coef_reg.yj <= cfg_data;
                REG_YC:  coef_reg.yc <= cfg_data;
                REG_WI:  coef_reg.wi <= cfg_data;
                REG_WJ:  coef_reg.wj <= cfg_data;
                default: coef_reg    <= coef_reg;
            endcase
        end
    end

    // front to back job queue
    logic push, pop, q_full, q_empty;
    job_t push_data, pop_data;

    ipr_front u_front (
        .req, .q_full, .push, .push_data
    );

    ipr_fifo #(.DEPTH(4)) u_fifo (
        .clk, .rst_n, .push, .push_data, .full (q_full),
        .pop, .pop_data, .empty (q_empty)
    );

    // back end: transform, divide, lookup; loads are written at the lookup stage
    ipr_back #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT)) u_back (
        .clk, .rst_n, .coef (coef_reg), .q_empty, .job (pop_data), .pop, .rsp
    );
endmodule
